[rtl/core/ddma_pkg.sv]
// shared widths, register indexes and reset values for the dust density moving average
package ddma_pkg;

    localparam int unsigned CODE_W         = 16;
    localparam int unsigned DENS_W         = 24;
    localparam int unsigned CFG_IDX_W      = 8;
    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned PROD_W         = 2 * CODE_W;
    localparam int unsigned SAMPLE_SHIFT   = 8;

    localparam int unsigned WINDOW_DEFAULT = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_LEVEL    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_SLOPE = CFG_IDX_W'(1);

    localparam logic [CODE_W-1:0] DARK_LEVEL_RESET    = CODE_W'(5200);
    localparam logic [CODE_W-1:0] DENSITY_SLOPE_RESET = CODE_W'(1393);

    localparam logic [DENS_W-1:0] DENS_MAX = {DENS_W{1'b1}};

endpackage

[rtl/core/ddma_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module ddma_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 100,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dust_density_moving_average_top.sv]
// dust density moving average: dark clamp, slope scaling and boxcar average over a ring
// One raw adc code is taken per beat on the s_ channel and one result beat leaves on the
// m_ channel for it, in order. The block takes a new beat every cycle when not stalled.
// Each beat passes through stages 1 to 3 and the output register, the depth being set by
// the registered read of the sample ring, the slope multiplier and the reciprocal
// multiplier that forms the average. Stalls on m_ready back up stage by stage, so empty
// stages still take beats while a result waits. The ring of WINDOW samples starts out as
// all zeros (per-entry valid bits, no clearing pass), so the average ramps up over the
// first WINDOW samples. Configuration writes (dark level, density slope) are taken every
// cycle and must only be issued while no beat is in flight.
module dust_density_moving_average_top #(
    parameter int unsigned WINDOW = ddma_pkg::WINDOW_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ddma_pkg::CODE_W-1:0]     s_raw_code,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ddma_pkg::DENS_W-1:0]     m_sample_density,
    output logic [ddma_pkg::DENS_W-1:0]     m_average_density,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ddma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddma_pkg::CFG_DATA_W-1:0] cfg_data
);

    import ddma_pkg::*;

    // ring position and running total widths
    localparam int unsigned L_W    = $clog2(WINDOW);
    localparam int unsigned POS_W  = (WINDOW > 1) ? L_W : 1;
    localparam int unsigned TOT_W  = DENS_W + L_W;
    // exact divide by WINDOW: floor(n * RECIP / 2^SHIFT) == n / WINDOW for n < 2^TOT_W
    localparam int unsigned SHIFT  = TOT_W + L_W;
    localparam int unsigned MULT_W = TOT_W + 1;
    localparam logic [MULT_W-1:0] RECIP =
        MULT_W'(((64'd1 << SHIFT) / 64'(WINDOW)) + 64'd1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
    localparam logic [TOT_W-1:0] TOT_MAX  = TOT_W'(64'(WINDOW) * 64'(DENS_MAX));

    // configuration registers
    logic [CODE_W-1:0] dark_level_reg;
    logic [CODE_W-1:0] density_slope_reg;

    // ring bookkeeping
    logic [POS_W-1:0]  wr_pos_reg;
    logic [POS_W-1:0]  wr_pos_next;
    logic [WINDOW-1:0] entry_vld_reg;
    logic [DENS_W-1:0] ring_rdata;

    // stage 1: input register, ring read in flight
    logic              v1_reg;
    logic [CODE_W-1:0] code1_reg;
    logic [POS_W-1:0]  pos1_reg;
    logic              oldv1_reg;
    logic              fwd1_reg;
    logic [DENS_W-1:0] fwdd1_reg;

    // stage 2: sample and the entry it replaces
    logic              v2_reg;
    logic [DENS_W-1:0] sample2_reg;
    logic [DENS_W-1:0] old2_reg;

    // stage 3: sample, running total holds this beat's total
    logic              v3_reg;
    logic [DENS_W-1:0] sample3_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;

    // output register
    logic              m_valid_reg;
    logic [DENS_W-1:0] m_sample_reg;
    logic [DENS_W-1:0] m_average_reg;

    // handshake chain
    logic ready_out;
    logic ready3;
    logic ready2;
    logic ready1;
    logic acc;
    logic move1;
    logic move2;
    logic move3;

    // datapath
    logic [CODE_W-1:0]       excess1;
    logic [PROD_W-1:0]       product1;
    logic [DENS_W-1:0]       sample1;
    logic [DENS_W-1:0]       old1;
    logic                    fwd_next;
    logic [TOT_W+MULT_W-1:0] avg_prod;

    // each stage moves when it is empty or the next one takes its beat
    assign ready_out = !m_valid_reg || m_ready;
    assign ready3    = !v3_reg || ready_out;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign acc       = s_valid && ready1;
    assign move1     = v1_reg && ready2;
    assign move2     = v2_reg && ready3;
    assign move3     = v3_reg && ready_out;

    assign s_ready   = ready1;
    assign cfg_ready = 1'b1;

    assign wr_pos_next = (wr_pos_reg == POS_LAST) ? '0 : wr_pos_reg + POS_W'(1);

    // same-cycle write of the position being read (only when the window is one entry)
    assign fwd_next = move1 && (pos1_reg == wr_pos_reg);

    // sample ring: read at accept, written when the sample leaves stage 1
    ddma_ram #(
        .WIDTH (DENS_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .aclk  (aclk),
        .we    (move1),
        .waddr (pos1_reg),
        .wdata (sample1),
        .re    (acc),
        .raddr (wr_pos_reg),
        .rdata (ring_rdata)
    );

    // stage 1 math: clamp at dark, scale by slope
    always_comb begin
        excess1  = (code1_reg > dark_level_reg) ? (code1_reg - dark_level_reg) : '0;
        product1 = PROD_W'(excess1) * PROD_W'(density_slope_reg);
        sample1  = product1[SAMPLE_SHIFT +: DENS_W];
        if (fwd1_reg) begin
            old1 = fwdd1_reg;
        end else if (oldv1_reg) begin
            old1 = ring_rdata;
        end else begin
            old1 = '0;
        end
    end

    // total drops the replaced entry and adds the new sample
    assign total_next = total_reg - TOT_W'(old2_reg) + TOT_W'(sample2_reg);

    // average by reciprocal multiply
    assign avg_prod = (TOT_W+MULT_W)'(total_reg) * (TOT_W+MULT_W)'(RECIP);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_level_reg    <= DARK_LEVEL_RESET;
            density_slope_reg <= DENSITY_SLOPE_RESET;
            wr_pos_reg        <= '0;
            entry_vld_reg     <= '0;
            total_reg         <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DARK_LEVEL: begin
                        dark_level_reg <= cfg_data;
                    end
                    CFG_DENSITY_SLOPE: begin
                        density_slope_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (acc) begin
                wr_pos_reg <= wr_pos_next;
            end
            if (move1) begin
                entry_vld_reg[pos1_reg] <= 1'b1;
            end
            if (move2) begin
                total_reg <= total_next;
            end
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
            if (ready_out) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (acc) begin
            code1_reg <= s_raw_code;
            pos1_reg  <= wr_pos_reg;
            oldv1_reg <= entry_vld_reg[wr_pos_reg];
            fwd1_reg  <= fwd_next;
            fwdd1_reg <= sample1;
        end
        if (move1) begin
            sample2_reg <= sample1;
            old2_reg    <= old1;
        end
        if (move2) begin
            sample3_reg <= sample2_reg;
        end
        if (move3) begin
            m_sample_reg  <= sample3_reg;
            m_average_reg <= avg_prod[SHIFT +: DENS_W];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_sample_density  = m_sample_reg;
    assign m_average_density = m_average_reg;

    // an empty output register never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty output register");

    // write position stays inside the ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pos_reg <= POS_LAST)
        else $error("ring position out of range");

    // running total can never exceed a full window of maximum samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        move2 |=> total_reg <= TOT_MAX)
        else $error("running total underflow or overflow");

endmodule
